// ===== hdl/mtc_pkg.sv =====
// Shared types and constants for the monotone triple counter.
package mtc_pkg;

  // Running total width and its saturation value
  localparam int unsigned TOTAL_W = 22;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;    // latch a new beat and open the scan
    logic scan_rd;  // issue one element read and advance the scan index
    logic finish;   // store the element, update the total, load the result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;      // capacity reached, the next element is dropped
    logic empty;     // no element held yet
    logic scan_end;  // the read being issued is the last held element
  } sts_t;

endpackage

// ===== hdl/mtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry each cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/mtc_ctrl.sv =====
// Controller state machine: accepts a beat, runs the scan, hands off the result.
module mtc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mtc_pkg::sts_t sts,
  output mtc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Decode state and status into commands and next state
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          if (sts.full || sts.empty) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted beat blocks further beats until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted while previous beat still in work");

  // The last read always drains into the finish step
  a_drain_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_FINISH))
    else $error("drain step did not lead to finish");

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready) |=> (state_r == S_FINISH))
    else $error("result loaded over a pending beat");

endmodule

// ===== hdl/mtc_datapath.sv =====
// Datapath: element memory, scan index, compare-and-accumulate, result register.
module mtc_datapath #(
  parameter int unsigned MAX_ITEMS  = 256,
  parameter int unsigned VALUE_BITS = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic                        in_last,
  input  mtc_pkg::cmd_t               cmd,
  output mtc_pkg::sts_t               sts,
  output logic [mtc_pkg::TOTAL_W-1:0] out_triple_count,
  output logic                        out_set_done,
  output logic                        out_dropped
);

  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ENTRY_W = VALUE_BITS + 2 * ADDR_W;
  localparam int unsigned TW     = mtc_pkg::TOTAL_W;

  // Set state
  logic [CNT_W-1:0]  items_r, items_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  // Beat in work
  logic [VALUE_BITS-1:0] val_r;
  logic                  last_r;
  logic                  drop_r;
  // Scan state
  logic [ADDR_W-1:0] idx_r;
  logic              rd_vld_r;
  logic [TW-1:0]     acc_r, acc_nxt;
  logic [ADDR_W-1:0] below_r, below_nxt;
  logic [ADDR_W-1:0] above_r, above_nxt;
  // Result register
  logic [TW-1:0]     res_count_r;
  logic              res_done_r;
  logic              res_drop_r;

  logic [ENTRY_W-1:0]    rd_data;
  logic [ENTRY_W-1:0]    wr_data;
  logic [VALUE_BITS-1:0] s_val;
  logic [ADDR_W-1:0]     s_smaller;
  logic [ADDR_W-1:0]     s_larger;
  logic [ADDR_W-1:0]     add_cnt;
  logic                  add_en;
  logic [TW:0]           sum;
  logic [TW-1:0]         new_total;

  // Element memory: {value, smaller-before, larger-before}
  assign wr_data = {val_r, below_r, above_r};

  mtc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_elem_ram (
    .clk     (clk),
    .wr_en   (cmd.finish && !drop_r),
    .wr_addr (items_r[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign {s_val, s_smaller, s_larger} = rd_data;

  // Status toward the controller
  assign sts.full     = (items_r == CNT_W'(MAX_ITEMS));
  assign sts.empty    = (items_r == '0);
  assign sts.scan_end = ((CNT_W'(idx_r) + CNT_W'(1)) == items_r);

  // Compare one returned element and add its count, saturating
  always_comb begin
    add_en  = 1'b0;
    add_cnt = '0;
    below_nxt = below_r;
    above_nxt = above_r;
    if (rd_vld_r) begin
      if (s_val < val_r) begin
        add_en    = 1'b1;
        add_cnt   = s_smaller;
        below_nxt = below_r + ADDR_W'(1);
      end else if (s_val > val_r) begin
        add_en    = 1'b1;
        add_cnt   = s_larger;
        above_nxt = above_r + ADDR_W'(1);
      end
    end
    sum     = {1'b0, acc_r} + (TW + 1)'(add_cnt);
    acc_nxt = acc_r;
    if (add_en) begin
      acc_nxt = sum[TW] ? mtc_pkg::TOTAL_MAX : sum[TW-1:0];
    end
  end

  // Close out the beat: new total, then clear on the last element
  always_comb begin
    new_total = drop_r ? total_r : acc_r;
    items_nxt = items_r;
    total_nxt = total_r;
    if (cmd.finish) begin
      if (last_r) begin
        items_nxt = '0;
        total_nxt = '0;
      end else begin
        items_nxt = items_r + CNT_W'(!drop_r);
        total_nxt = new_total;
      end
    end
  end

  // Hold set state and the read-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_r  <= '0;
      total_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      items_r  <= items_nxt;
      total_r  <= total_nxt;
      rd_vld_r <= cmd.scan_rd;
    end
  end

  // Latch the beat, advance the scan, load the result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      val_r   <= in_value;
      last_r  <= in_last;
      drop_r  <= sts.full;
      idx_r   <= '0;
      acc_r   <= total_r;
      below_r <= '0;
      above_r <= '0;
    end else begin
      if (cmd.scan_rd) begin
        idx_r <= idx_r + ADDR_W'(1);
      end
      acc_r   <= acc_nxt;
      below_r <= below_nxt;
      above_r <= above_nxt;
    end
    if (cmd.finish) begin
      res_count_r <= new_total;
      res_done_r  <= last_r;
      res_drop_r  <= drop_r;
    end
  end

  assign out_triple_count = res_count_r;
  assign out_set_done     = res_done_r;
  assign out_dropped      = res_drop_r;

  // The element count never passes capacity
  a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");

endmodule

// ===== hdl/monotone_triple_counter_core.sv =====
// Top level of the monotone triple counter: controller plus datapath.
// Counts index triples i<j<k of the current set whose values rise or fall
// strictly, and answers every input beat with the running total of the set.
// For each beat the datapath compares the new value against each stored
// element, one per cycle, read from a single-port-read element memory of
// MAX_ITEMS entries; an empty or full set skips this scan. A drain step
// takes the last read, and a finish step stores the element and loads the
// result once the output is free. A beat marked last closes the set;
// elements that arrive with MAX_ITEMS already held are dropped and flagged.
// The total saturates at its all-ones value. The next beat is taken while a
// result still waits on the output.
module monotone_triple_counter_core #(
  parameter int unsigned MAX_ITEMS  = 256,
  parameter int unsigned VALUE_BITS = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtc_pkg::TOTAL_W-1:0] out_triple_count,
  output logic                        out_set_done,
  output logic                        out_dropped
);

  mtc_pkg::cmd_t cmd;
  mtc_pkg::sts_t sts;

  mtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtc_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .in_last          (in_last),
    .cmd              (cmd),
    .sts              (sts),
    .out_triple_count (out_triple_count),
    .out_set_done     (out_set_done),
    .out_dropped      (out_dropped)
  );

endmodule
